/* rtl/core/prwa_pkg.sv */
// ============================================================================
// prwa_pkg
// Shared types and constants of the peer registry with aging.
// ============================================================================
package prwa_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_LIST        = 32;
    localparam int LIST_CNT_W      = $clog2(MAX_LIST);
    localparam logic [15:0] TIMEOUT_RESET = 16'd600;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int TIME_W = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_HEARTBEAT = 3'd1,
        ACT_SHUTDOWN  = 3'd2,
        ACT_LIST      = 3'd3,
        ACT_PING      = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_REFRESHED  = 3'd0,
        ST_ADDED      = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_REMOVED    = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_LIST_ENTRY = 3'd5,
        ST_LIST_EMPTY = 3'd6,
        ST_PING_ACK   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        SRC_REQ,
        SRC_MEM,
        SRC_ZERO
    } t_src;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SWEEP,
        FSM_SWEEP_FIN,
        FSM_ACT,
        FSM_LIST_SCAN,
        FSM_LIST_EMIT
    } t_fsm;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
        logic              keep;
    } t_entry;

    typedef struct packed {
        logic    accept;
        logic    sweep_rd;
        logic    list_rd;
        logic    ptr_inc;
        logic    scan_clr;
        logic    write_add;
        logic    write_refresh;
        logic    clear_match;
        logic    emit;
        t_status status;
        t_src    src;
    } t_dp_cmd;

    typedef struct packed {
        logic    in_is_tick;
        t_action req_action;
        logic    scan_last;
        logic    match_found;
        logic    free_found;
        logic    any_valid;
        logic    ptr_valid;
        logic    list_last;
        logic    out_free;
    } t_dp_stat;

endpackage

/* rtl/core/prwa_datapath.sv */
// ============================================================================
// prwa_datapath
// Entry memory, valid bits, seconds clock, sweep evaluation and result register.
// ============================================================================
module prwa_datapath #(
    parameter int TABLE_DEPTH = prwa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prwa_pkg::t_dp_cmd           i_cmd,
    output prwa_pkg::t_dp_stat          o_stat,
    input  logic                        i_cfg_we,
    input  logic [15:0]                 i_cfg_wdata,
    // tdata: peer_address[31:0], peer_port[47:32], keep_forever[48], zero fill
    input  logic [prwa_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: action[2:0]
    input  logic [2:0]                  i_s_tuser,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    // tdata: entry_address[31:0], entry_port[47:32]
    output logic [prwa_pkg::M_DATA_W-1:0] o_m_tdata,
    // tuser: status[2:0]
    output logic [2:0]                  o_m_tuser,
    output logic                        o_m_tlast
);
    import prwa_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TIME_W-1:0]      r_time;
    logic [15:0]            r_timeout;

    t_action           r_req_action;
    logic [ADDR_W-1:0] r_req_addr;
    logic [PORT_W-1:0] r_req_port;
    logic              r_req_keep;

    logic [IDX_W-1:0]      r_ptr;
    logic                  r_eval_pend;
    logic [IDX_W-1:0]      r_eval_idx;
    logic                  r_match_found;
    logic [IDX_W-1:0]      r_match_idx;
    logic                  r_match_keep;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic [LIST_CNT_W-1:0] r_list_cnt;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_addr;
    logic [PORT_W-1:0] r_out_port;
    logic              r_out_last;

    logic [TIME_W-1:0] age;
    logic              eval_valid;
    logic              expired;
    logic              alive;
    logic              is_match;
    logic              higher_valid;
    logic              list_last;
    logic              out_free;

    // Evaluation of the entry read in the previous cycle of the sweep.
    assign age        = r_time - r_rd_data.stamp;
    assign eval_valid = r_valid[r_eval_idx];
    assign expired    = !r_rd_data.keep && (age > {16'd0, r_timeout});
    assign alive      = eval_valid && !expired;
    assign is_match   = alive && (r_rd_data.addr == r_req_addr)
                        && (r_rd_data.port == r_req_port);

    always_comb begin
        higher_valid = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (r_valid[i] && (i > int'(r_ptr))) begin
                higher_valid = 1'b1;
            end
        end
    end

    assign list_last = !higher_valid || (r_list_cnt == LIST_CNT_W'(MAX_LIST - 1));
    assign out_free  = !r_out_valid || i_m_tready;

    always_comb begin
        o_stat             = '0;
        o_stat.in_is_tick  = (i_s_tuser == ACT_TICK);
        o_stat.req_action  = r_req_action;
        o_stat.scan_last   = (r_ptr == IDX_W'(TABLE_DEPTH - 1));
        o_stat.match_found = r_match_found;
        o_stat.free_found  = r_free_found;
        o_stat.any_valid   = |r_valid;
        o_stat.ptr_valid   = r_valid[r_ptr];
        o_stat.list_last   = list_last;
        o_stat.out_free    = out_free;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_add) begin
            r_mem[r_free_idx] <= '{addr: r_req_addr, port: r_req_port,
                                   stamp: r_time, keep: r_req_keep};
        end else if (i_cmd.write_refresh) begin
            r_mem[r_match_idx] <= '{addr: r_req_addr, port: r_req_port,
                                    stamp: r_time, keep: r_match_keep};
        end
        if (i_cmd.sweep_rd || i_cmd.list_rd) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_action <= t_action'(i_s_tuser);
            r_req_addr   <= i_s_tdata[31:0];
            r_req_port   <= i_s_tdata[47:32];
            r_req_keep   <= i_s_tdata[48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_time        <= '0;
            r_timeout     <= TIMEOUT_RESET;
            r_ptr         <= '0;
            r_eval_pend   <= 1'b0;
            r_eval_idx    <= '0;
            r_match_found <= 1'b0;
            r_match_idx   <= '0;
            r_match_keep  <= 1'b0;
            r_free_found  <= 1'b0;
            r_free_idx    <= '0;
            r_list_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.accept && (i_s_tuser == ACT_TICK)) begin
                r_time <= r_time + 1'b1;
            end

            r_eval_pend <= i_cmd.sweep_rd;
            if (i_cmd.sweep_rd) begin
                r_eval_idx <= r_ptr;
            end

            if (i_cmd.accept || i_cmd.scan_clr) begin
                r_ptr         <= '0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
                r_list_cnt    <= '0;
            end else begin
                if (i_cmd.sweep_rd || i_cmd.ptr_inc) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (i_cmd.emit && (i_cmd.src == SRC_MEM)) begin
                    r_list_cnt <= r_list_cnt + 1'b1;
                end
                if (r_eval_pend) begin
                    if (eval_valid && expired) begin
                        r_valid[r_eval_idx] <= 1'b0;
                    end
                    if (is_match && !r_match_found) begin
                        r_match_found <= 1'b1;
                        r_match_idx   <= r_eval_idx;
                        r_match_keep  <= r_rd_data.keep;
                    end
                    if (!alive && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_eval_idx;
                    end
                end
            end

            if (i_cmd.write_add) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (i_cmd.clear_match) begin
                r_valid[r_match_idx] <= 1'b0;
            end
        end
    end

    // Result register: holds one transfer until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            case (i_cmd.src)
                SRC_MEM: begin
                    r_out_addr <= r_rd_data.addr;
                    r_out_port <= r_rd_data.port;
                    r_out_last <= list_last;
                end
                SRC_ZERO: begin
                    r_out_addr <= '0;
                    r_out_port <= '0;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_addr <= r_req_addr;
                    r_out_port <= r_req_port;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_port, r_out_addr};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

/* rtl/core/prwa_ctrl.sv */
// ============================================================================
// prwa_ctrl
// Sequencer for sweep, table update and list walk of the peer registry.
// ============================================================================
module prwa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output prwa_pkg::t_dp_cmd   o_cmd,
    input  prwa_pkg::t_dp_stat  i_stat
);
    import prwa_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_PING_ACK;
        o_cmd.src    = SRC_REQ;
        o_s_tready = 1'b0;

        unique case (r_state)
            FSM_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_stat.in_is_tick) begin
                        n_state = FSM_SWEEP;
                    end
                end
            end
            FSM_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = FSM_SWEEP_FIN;
                end
            end
            FSM_SWEEP_FIN: begin
                // The last entry read is evaluated in this cycle.
                n_state = FSM_ACT;
            end
            FSM_ACT: begin
                unique case (i_stat.req_action)
                    ACT_HEARTBEAT: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.match_found) begin
                                o_cmd.write_refresh = 1'b1;
                                o_cmd.status        = ST_REFRESHED;
                            end else if (i_stat.free_found) begin
                                o_cmd.write_add = 1'b1;
                                o_cmd.status    = ST_ADDED;
                            end else begin
                                o_cmd.status = ST_TABLE_FULL;
                            end
                            n_state = FSM_IDLE;
                        end
                    end
                    ACT_SHUTDOWN: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.match_found) begin
                                o_cmd.clear_match = 1'b1;
                                o_cmd.status      = ST_REMOVED;
                            end else begin
                                o_cmd.status = ST_NOT_FOUND;
                            end
                            n_state = FSM_IDLE;
                        end
                    end
                    ACT_LIST: begin
                        if (i_stat.any_valid) begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = FSM_LIST_SCAN;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_LIST_EMPTY;
                            o_cmd.src    = SRC_ZERO;
                            n_state      = FSM_IDLE;
                        end
                    end
                    ACT_PING: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_PING_ACK;
                            n_state      = FSM_IDLE;
                        end
                    end
                    default: begin
                        n_state = FSM_IDLE;
                    end
                endcase
            end
            FSM_LIST_SCAN: begin
                if (i_stat.ptr_valid) begin
                    o_cmd.list_rd = 1'b1;
                    n_state       = FSM_LIST_EMIT;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            FSM_LIST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.status  = ST_LIST_ENTRY;
                    o_cmd.src     = SRC_MEM;
                    o_cmd.ptr_inc = 1'b1;
                    n_state = i_stat.list_last ? FSM_IDLE : FSM_LIST_SCAN;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/peer_registry_with_aging.sv */
// ============================================================================
// peer_registry_with_aging
// Table of peers keyed by address and port, with timeout of stale entries.
// ============================================================================
// Requests arrive on the s_axis channel, one transfer per request, with the
// action in tuser. Results leave on the m_axis channel; tlast marks the final
// result of a request. The user must write the timeout through i_cfg_we and
// i_cfg_wdata only while the block is idle; the block does not enforce this.
// A tick is accepted without leaving idle and gives no result. Every other
// request first sweeps the table, reading one entry per cycle from the entry
// memory; its result is loaded once the sweep is evaluated and the output
// register is free, and the next request is taken when the block is back in
// idle. A list request then walks the table again, one entry per cycle while
// it skips invalid entries, and emits each valid one once the output is free.
// Reset clears all entries, the seconds clock and the output, and restores a
// timeout of 600. A stalled receiver holds the result in the output register;
// the block waits with the next result until that transfer has completed,
// but accepts a new request while the last result is still waiting.
// ============================================================================
module peer_registry_with_aging #(
    parameter int TABLE_DEPTH = prwa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: peer_address[31:0], peer_port[47:32], keep_forever[48], zero fill
    input  logic [prwa_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: action[2:0]
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: entry_address[31:0], entry_port[47:32]
    output logic [prwa_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import prwa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    prwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    prwa_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

/* tb/sv/tb.sv */
// ============================================================================
// tb
// Self-checking testbench for peer_registry_with_aging.
// ============================================================================
// Requests go in on the slave stream. Each accepted transfer is also run
// through a behavioural copy of the peer table, with its own seconds clock,
// timeout and aging sweep, and the results that the copy gives are queued.
// Every result transfer is checked against the oldest queued result. The
// stimulus starts with directed requests and goes on with random traffic
// over a small set of peers, then fills the table, and once holds the
// result stream off for a long stretch while requests keep arriving.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prwa_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 3 * (DEPTH + 2);
    localparam int RX_HOLD_CYCLES = 1200;
    localparam int CYCLE_LIMIT    = 4_000_000;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_SIZE      = 16;
    localparam int FILL_SIZE      = 40;

    localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

    typedef struct {
        t_status     status;
        logic [31:0] addr;
        logic [15:0] port;
        logic        last;
    } t_peer_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [15:0]           i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    // Behavioural copy of the peer table.
    logic                  tbl_valid [DEPTH];
    logic [31:0]           tbl_addr  [DEPTH];
    logic [15:0]           tbl_port  [DEPTH];
    logic [31:0]           tbl_stamp [DEPTH];
    logic                  tbl_keep  [DEPTH];
    logic [31:0]           now_ticks;
    logic [15:0]           timeout_setting;

    t_peer_result          pending_results[$];
    t_peer_result          rx_want;

    logic [31:0]           pool_addr [POOL_SIZE];
    logic [15:0]           pool_port [POOL_SIZE];
    logic [31:0]           fill_addr [FILL_SIZE];
    logic [15:0]           fill_port [FILL_SIZE];

    bit                    tx_idle = 1'b1;
    bit                    rx_idle = 1'b1;
    bit                    rx_hold_req = 1'b0;
    int                    rx_stall_left = 0;

    int                    error_count = 0;
    int                    results_checked = 0;
    int                    requests_sent = 0;
    int                    timeout_writes = 0;
    int                    list_entries = 0;
    int                    full_replies = 0;
    int                    aged_out = 0;
    int                    input_stalls = 0;
    int                    cycle_count = 0;

    peer_registry_with_aging uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata: peer_address[31:0], peer_port[47:32], keep_forever[48], zero fill
        .s_axis_tdata  (s_axis_tdata),
        // tuser: action[2:0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata: entry_address[31:0], entry_port[47:32]
        .m_axis_tdata  (m_axis_tdata),
        // tuser: status[2:0]
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic void push_result(input t_status st, input logic [31:0] addr,
                                        input logic [15:0] port, input logic last);
        t_peer_result r;
        r.status = st;
        r.addr   = addr;
        r.port   = port;
        r.last   = last;
        pending_results.push_back(r);
        if (st == ST_LIST_ENTRY)
            list_entries++;
        if (st == ST_TABLE_FULL)
            full_replies++;
    endfunction

    function automatic void predict_request(input logic [2:0] act, input logic [31:0] addr,
                                            input logic [15:0] port, input logic keep);
        logic [31:0] age;
        int          hit;
        int          slot;
        int          total;
        int          n;
        hit  = -1;
        slot = -1;
        if (act == ACT_TICK) begin
            now_ticks = now_ticks + 32'd1;
            return;
        end
        // Every request other than a tick first ages out stale entries.
        for (int i = 0; i < DEPTH; i++) begin
            age = now_ticks - tbl_stamp[i];
            if (tbl_valid[i] && !tbl_keep[i] && age > {16'd0, timeout_setting}) begin
                tbl_valid[i] = 1'b0;
                aged_out++;
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_addr[i] == addr && tbl_port[i] == port)
                hit = i;
            if (!tbl_valid[i])
                slot = i;
        end
        case (act)
            ACT_HEARTBEAT: begin
                if (hit >= 0) begin
                    tbl_stamp[hit] = now_ticks;
                    push_result(ST_REFRESHED, addr, port, 1'b1);
                end else if (slot >= 0) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_addr[slot]  = addr;
                    tbl_port[slot]  = port;
                    tbl_stamp[slot] = now_ticks;
                    tbl_keep[slot]  = keep;
                    push_result(ST_ADDED, addr, port, 1'b1);
                end else begin
                    push_result(ST_TABLE_FULL, addr, port, 1'b1);
                end
            end
            ACT_SHUTDOWN: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    push_result(ST_REMOVED, addr, port, 1'b1);
                end else begin
                    push_result(ST_NOT_FOUND, addr, port, 1'b1);
                end
            end
            ACT_LIST: begin
                total = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && total < MAX_LIST)
                        total++;
                if (total == 0) begin
                    push_result(ST_LIST_EMPTY, 32'd0, 16'd0, 1'b1);
                end else begin
                    n = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (tbl_valid[i] && n < total) begin
                            n++;
                            push_result(ST_LIST_ENTRY, tbl_addr[i], tbl_port[i], n == total);
                        end
                    end
                end
            end
            ACT_PING: push_result(ST_PING_ACK, addr, port, 1'b1);
            default: ;
        endcase
    endfunction

    // Result checker: one transfer per rising edge at most.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result: status %0d addr %h port %h last %b",
                                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
                                     m_axis_tlast));
            end else begin
                rx_want = pending_results.pop_front();
                results_checked++;
                if (m_axis_tuser !== rx_want.status || m_axis_tdata[31:0] !== rx_want.addr ||
                    m_axis_tdata[47:32] !== rx_want.port || m_axis_tlast !== rx_want.last)
                    note_error($sformatf({"result %0d: expected status %0d addr %h port %h ",
                                          "last %b, got status %0d addr %h port %h last %b"},
                                         results_checked, rx_want.status, rx_want.addr,
                                         rx_want.port, rx_want.last, m_axis_tuser,
                                         m_axis_tdata[31:0], m_axis_tdata[47:32],
                                         m_axis_tlast));
            end
        end
    end

    // Result receiver. A hold request keeps tready low for a long, counted stretch.
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_stall_left = RX_HOLD_CYCLES;
        end
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_idle)
                rx_stall_left = idle_len();
        end
    end

    task automatic send_request(input logic [2:0] act, input logic [31:0] addr,
                                input logic [15:0] port, input logic keep);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(S_DATA_W - 49){1'b0}}, keep, port, addr};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        predict_request(act, addr, port, keep);
        requests_sent++;
        gap = tx_idle ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering requests and waits until the block has gone quiet.
    task automatic drain_requests();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        drain_requests();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_setting = value;
        timeout_writes++;
    endtask

    task automatic test_directed_basics();
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
        send_request(ACT_PING, 32'd0, 16'd0, 1'b0);
        send_request(ACT_PING, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_request(ACT_HEARTBEAT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_request(ACT_HEARTBEAT, 32'd0, 16'd0, 1'b0);
        // A refresh must not clear the keep-forever flag set when the peer was added.
        send_request(ACT_HEARTBEAT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_request(ACT_HEARTBEAT, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        send_request(ACT_SHUTDOWN, 32'd0, 16'd0, 1'b0);
        send_request(ACT_SHUTDOWN, 32'd0, 16'd0, 1'b0);
        send_request(ACT_HEARTBEAT, 32'd0, 16'd0, 1'b0);
        send_request(ACT_LIST, 32'h1234_5678, 16'h9ABC, 1'b1);
        for (logic [2:0] a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++) begin
            send_request(a, $urandom(), 16'($urandom()), 1'b1);
            if (a == ACT_RESERVED_LAST)
                break;
        end
    endtask

    task automatic test_directed_aging();
        set_timeout(16'd2);
        send_request(ACT_HEARTBEAT, 32'h0A00_0001, 16'd5000, 1'b0);
        send_request(ACT_TICK, 32'd0, 16'd0, 1'b0);
        send_request(ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // Ages equal to the timeout survive; one more tick frees them.
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
        send_request(ACT_TICK, 32'd0, 16'd0, 1'b0);
        send_request(ACT_PING, 32'h0A00_0002, 16'd7, 1'b0);
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
        send_request(ACT_HEARTBEAT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        // With a zero timeout only keep-forever entries and entries stamped at the current second survive.
        set_timeout(16'd0);
        send_request(ACT_HEARTBEAT, 32'hC0A8_0101, 16'd27500, 1'b0);
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
        send_request(ACT_TICK, 32'd0, 16'd0, 1'b0);
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
    endtask

    // Random requests over a small set of peers, so that refreshes, removals and
    // aging all happen often. One request in ten uses an unrelated peer.
    task automatic test_random_churn(input int count, input int tick_pct);
        int          r;
        int          p;
        logic [2:0]  act;
        logic [31:0] addr;
        logic [15:0] port;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_SIZE - 1);
            addr = pool_addr[p];
            port = pool_port[p];
            if ($urandom_range(0, 9) == 0) begin
                addr = $urandom();
                port = 16'($urandom());
            end
            if (r < tick_pct)
                act = ACT_TICK;
            else if (r < tick_pct + 38)
                act = ACT_HEARTBEAT;
            else if (r < tick_pct + 53)
                act = ACT_SHUTDOWN;
            else if (r < tick_pct + 61)
                act = ACT_LIST;
            else if (r < tick_pct + 68)
                act = ACT_PING;
            else
                act = 3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
            send_request(act, addr, port, $urandom_range(0, 3) == 0);
        end
    endtask

    // Fills the table past capacity, then lists it while the receiver is held off.
    task automatic test_table_full_and_backpressure();
        set_timeout(16'hFFFF);
        for (int k = 0; k < FILL_SIZE; k++)
            send_request(ACT_HEARTBEAT, fill_addr[k], fill_port[k], 1'(k % 2));
        rx_hold_req = 1'b1;
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
        send_request(ACT_PING, $urandom(), 16'($urandom()), 1'b0);
        send_request(ACT_HEARTBEAT, fill_addr[FILL_SIZE - 1], fill_port[FILL_SIZE - 1], 1'b0);
        send_request(ACT_HEARTBEAT, $urandom(), 16'($urandom()), 1'b1);
        send_request(ACT_SHUTDOWN, $urandom(), 16'($urandom()), 1'b0);
        send_request(ACT_TICK, 32'd0, 16'd0, 1'b0);
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b1);
        for (int k = 0; k < 4; k++)
            send_request(ACT_SHUTDOWN, fill_addr[k * 3], fill_port[k * 3], 1'b0);
        for (int k = 0; k < 4; k++)
            send_request(ACT_HEARTBEAT, $urandom(), 16'($urandom()), 1'($urandom()));
        send_request(ACT_LIST, 32'd0, 16'd0, 1'b0);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_port[i]  = '0;
            tbl_stamp[i] = '0;
            tbl_keep[i]  = 1'b0;
        end
        now_ticks = '0;
        timeout_setting = TIMEOUT_RESET;
        // Odd peers share the address of their neighbour, so only the port tells them apart.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_addr[i] = (i % 2 == 1) ? pool_addr[i - 1] : $urandom();
            pool_port[i] = 16'($urandom());
        end
        for (int i = 0; i < FILL_SIZE; i++) begin
            fill_addr[i] = $urandom();
            fill_port[i] = 16'($urandom());
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_directed_basics();
        test_directed_aging();

        set_timeout(16'd1);
        test_random_churn(70, 25);

        set_timeout(16'($urandom_range(2, 8)));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_churn(40, 30);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_random_churn(50, 30);

        test_table_full_and_backpressure();

        set_timeout(TIMEOUT_RESET);
        test_random_churn(20, 20);

        drain_requests();
        if (pending_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived", pending_results.size()));
        $display("Covered %0d requests and %0d timeout writes; %0d results checked.",
                 requests_sent, timeout_writes, results_checked);
        $display("%0d listed entries, %0d table-full replies, %0d entries aged out, %0d stalls.",
                 list_entries, full_replies, aged_out, input_stalls);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d errors in total.", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/prwa_pkg.sv
rtl/core/prwa_datapath.sv
rtl/core/prwa_ctrl.sv
rtl/core/peer_registry_with_aging.sv
tb/sv/tb.sv
